// ----- hdl/pip_pkg.sv -----
// package for the point-in-polygon test block
// item kind codes and fixed field widths; no dependencies
`default_nettype none

package pip_pkg;

    localparam int KIND_W  = 2;
    localparam int FIELD_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/pip_if.sv -----
// valid/ready channel interfaces for the point-in-polygon test block
// depends on pip_pkg for the field widths
`default_nettype none

interface pip_req_if
    import pip_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;

    modport source (output valid, output kind, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input kind, input x_coord, input y_coord, output ready);
endinterface

interface pip_rsp_if
    import pip_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic [COUNT_W-1:0] crossing_count;
    logic               polygon_empty;

    modport source (output valid, output inside_res, output crossing_count,
                    output polygon_empty, input ready);
    modport sink   (input valid, input inside_res, input crossing_count,
                    input polygon_empty, output ready);
endinterface

`default_nettype wire

// ----- hdl/pip_cell.sv -----
// one edge cell of the point-in-polygon chain: holds one vertex, tests the
// edge to the next vertex against the query point, adds to the passing count
`default_nettype none

module pip_cell #(
    parameter int COORD_WIDTH = 32,
    parameter int CNT_W       = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          vld,
    input  wire logic                          wr_en,
    input  wire logic signed [COORD_WIDTH-1:0] wr_x,
    input  wire logic signed [COORD_WIDTH-1:0] wr_y,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] nx,
    input  wire logic signed [COORD_WIDTH-1:0] ny,
    output logic signed [COORD_WIDTH-1:0]      vx,
    output logic signed [COORD_WIDTH-1:0]      vy,
    input  wire logic                          tok_in_vld,
    input  wire logic [CNT_W-1:0]              tok_in_cnt,
    output logic                               tok_out_vld,
    output logic [CNT_W-1:0]                   tok_out_cnt
);

    localparam int D_W = COORD_WIDTH + 1;
    localparam int P_W = 2 * D_W;

    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;

    logic signed [D_W-1:0] a_next, b_next, c_next, d_next;
    logic                  hit_next, up_next;
    logic signed [D_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic                  hit1_reg, up1_reg;
    logic signed [P_W-1:0] ab_reg, cd_reg;
    logic                  hit2_reg, up2_reg;
    logic                  cross_reg;
    logic                  tok_vld_reg;
    logic [CNT_W-1:0]      tok_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
    end

    assign vx = x_reg;
    assign vy = y_reg;

    // edge from this vertex (x1,y1) to the next one (x2,y2)
    always_comb
    begin
        a_next   = D_W'(py) - D_W'(y_reg);
        b_next   = D_W'(nx) - D_W'(x_reg);
        c_next   = D_W'(px) - D_W'(x_reg);
        d_next   = D_W'(ny) - D_W'(y_reg);
        up_next  = ny > y_reg;
        hit_next = vld && (((y_reg <= py) && (py < ny)) || ((ny <= py) && (py < y_reg)));
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        hit1_reg <= hit_next;
        up1_reg  <= up_next;
        ab_reg   <= a_reg * b_reg;
        cd_reg   <= c_reg * d_reg;
        hit2_reg <= hit1_reg;
        up2_reg  <= up1_reg;
        // crossing lies right of px; sense of the compare follows the sign of dy
        cross_reg <= hit2_reg && (up2_reg ? (ab_reg > cd_reg) : (cd_reg > ab_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= tok_in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_cnt_reg <= tok_in_cnt + CNT_W'(cross_reg);
    end

    assign tok_out_vld = tok_vld_reg;
    assign tok_out_cnt = tok_cnt_reg;

endmodule

`default_nettype wire

// ----- hdl/point_in_polygon_test.sv -----
// Even-odd point-in-polygon test over a stored polygon of up to MAX_VERTICES
// vertices. An append to a full polygon is dropped. A query result is valid
// once the difference, multiply and compare stages of every edge cell hold
// the query and a count token has then walked the chain of edge cells, one
// cell per cycle. One query is in flight at a time; a new transaction is
// taken once the previous result has been taken or is being taken.
// depends on pip_pkg, pip_if and pip_cell
`default_nettype none

module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pip_req_if.sink    req,
    pip_rsp_if.source  rsp
);

    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);

    logic signed [COORD_WIDTH-1:0] x_in, y_in;
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic [VCNT_W-1:0]             vcnt_reg, vcnt_next;
    logic                          busy_reg, busy_next;
    logic [3:0]                    dly_reg, dly_next;
    logic                          out_vld_reg, out_vld_next;
    logic [VCNT_W-1:0]             res_cnt_reg;
    logic                          res_empty_reg;
    logic                          req_acc, rsp_acc, query_acc, append_acc, done;

    logic [MAX_VERTICES-1:0]       vld;
    logic [MAX_VERTICES-1:0]       wr_en;
    logic signed [COORD_WIDTH-1:0] vx [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vy [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] nx [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] ny [MAX_VERTICES];
    logic                          tv [MAX_VERTICES+1];
    logic [VCNT_W-1:0]             tc [MAX_VERTICES+1];

    // a coordinate is its field cut or zero-extended to COORD_WIDTH bits
    generate
        if (COORD_WIDTH <= FIELD_W)
        begin : g_narrow
            assign x_in = req.x_coord[COORD_WIDTH-1:0];
            assign y_in = req.y_coord[COORD_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign x_in = {{(COORD_WIDTH-FIELD_W){1'b0}}, req.x_coord};
            assign y_in = {{(COORD_WIDTH-FIELD_W){1'b0}}, req.y_coord};
        end
    endgenerate

    assign req.ready  = !busy_reg && (!out_vld_reg || rsp.ready);
    assign req_acc    = req.valid && req.ready;
    assign rsp_acc    = out_vld_reg && rsp.ready;
    assign query_acc  = req_acc && (req.kind == KIND_QUERY);
    assign append_acc = req_acc && (req.kind == KIND_APPEND);
    assign done       = tv[MAX_VERTICES];

    always_comb
    begin
        vcnt_next = vcnt_reg;
        if (req_acc)
        begin
            unique case (req.kind)
                KIND_CLEAR:  vcnt_next = '0;
                KIND_APPEND:
                begin
                    if (vcnt_reg < VCNT_W'(MAX_VERTICES))
                    begin
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                end
                default:     vcnt_next = vcnt_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        out_vld_next = out_vld_reg;
        dly_next     = {dly_reg[2:0], query_acc};
        if (query_acc)
        begin
            busy_next = 1'b1;
        end
        if (rsp_acc)
        begin
            out_vld_next = 1'b0;
        end
        if (done)
        begin
            busy_next    = 1'b0;
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg    <= '0;
            busy_reg    <= 1'b0;
            dly_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vcnt_reg    <= vcnt_next;
            busy_reg    <= busy_next;
            dly_reg     <= dly_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            px_reg <= x_in;
            py_reg <= y_in;
        end
        if (done)
        begin
            res_cnt_reg   <= tc[MAX_VERTICES];
            res_empty_reg <= (vcnt_reg == '0);
        end
    end

    // token enters once the compare stage of every cell holds this query
    assign tv[0] = dly_reg[3];
    assign tc[0] = '0;

    generate
        for (genvar k = 0; k < MAX_VERTICES; k++)
        begin : g_cell
            assign vld[k]   = VCNT_W'(k) < vcnt_reg;
            assign wr_en[k] = append_acc && (vcnt_reg == VCNT_W'(k));

            // the last stored vertex closes the polygon back to vertex 0
            if (k < MAX_VERTICES - 1)
            begin : g_mid
                assign nx[k] = vld[k+1] ? vx[k+1] : vx[0];
                assign ny[k] = vld[k+1] ? vy[k+1] : vy[0];
            end
            else
            begin : g_last
                assign nx[k] = vx[0];
                assign ny[k] = vy[0];
            end

            pip_cell #(
                .COORD_WIDTH (COORD_WIDTH),
                .CNT_W       (VCNT_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .vld         (vld[k]),
                .wr_en       (wr_en[k]),
                .wr_x        (x_in),
                .wr_y        (y_in),
                .px          (px_reg),
                .py          (py_reg),
                .nx          (nx[k]),
                .ny          (ny[k]),
                .vx          (vx[k]),
                .vy          (vy[k]),
                .tok_in_vld  (tv[k]),
                .tok_in_cnt  (tc[k]),
                .tok_out_vld (tv[k+1]),
                .tok_out_cnt (tc[k+1])
            );
        end
    endgenerate

    assign rsp.valid          = out_vld_reg;
    assign rsp.inside_res     = res_cnt_reg[0];
    assign rsp.crossing_count = COUNT_W'(res_cnt_reg);
    assign rsp.polygon_empty  = res_empty_reg;

endmodule

`default_nettype wire
